/* rtl/core/gcs_pkg.sv */
package gcs_pkg;

    localparam int unsigned PIXEL_W      = 32;
    localparam int unsigned RGB_W        = 24;
    localparam int unsigned COORD_W      = 7;
    localparam int unsigned NUMBER_W     = 6;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 9;
    localparam int unsigned WIDTH_REG_W  = 8;
    localparam int unsigned HEIGHT_REG_W = 9;

    localparam int unsigned DEF_MAX_WIDTH  = 128;
    localparam int unsigned DEF_MAX_HEIGHT = 256;

    localparam int unsigned RST_WIDTH    = 128;
    localparam int unsigned RST_HEIGHT   = 16;
    localparam int unsigned RESULT_LIMIT = 64;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    typedef struct packed {
        logic rotate;
        logic shift;
    } t_cell_ctl;

    typedef struct packed {
        logic [COORD_W-1:0]  left;
        logic [COORD_W-1:0]  right;
        logic [NUMBER_W-1:0] number;
        logic                none;
        logic                last;
    } t_glyph;

    // effective size minus one, size clamped to 1..lim
    function automatic int unsigned clamp_m1(input int unsigned v, input int unsigned lim);
        int unsigned c;
        c = v;
        if (c < 1) c = 1;
        if (c > lim) c = lim;
        return c - 1;
    endfunction

endpackage

/* rtl/core/gcs_pix_if.sv */
interface gcs_pix_if
    import gcs_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/core/gcs_glyph_if.sv */
interface gcs_glyph_if
    import gcs_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [COORD_W-1:0]  glyph_left;
    logic [COORD_W-1:0]  glyph_right;
    logic [NUMBER_W-1:0] glyph_number;
    logic                none_found;
    logic                last_glyph;

    modport source (output valid, output glyph_left, output glyph_right,
                    output glyph_number, output none_found, output last_glyph,
                    input ready);
    modport sink   (input valid, input glyph_left, input glyph_right,
                    input glyph_number, input none_found, input last_glyph,
                    output ready);
endinterface

/* rtl/core/gcs_cell.sv */
module gcs_cell
    import gcs_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_is_tail,
    input  logic      i_next,
    input  logic      i_feed,
    output logic      o_flag
);

    logic r_flag;

    always_ff @(posedge i_clk) begin
        if (i_ctl.rotate) begin
            r_flag <= i_is_tail ? i_feed : i_next;
        end else if (i_ctl.shift) begin
            r_flag <= i_next;
        end
    end

    assign o_flag = r_flag;

endmodule

/* rtl/core/glyph_column_segmenter.sv */
// channel   dir  handshake      payload
// i_pix     in   valid/ready    pixel[31:0] ARGB, alpha ignored
// o_glyph   out  valid/ready    glyph_left, glyph_right, glyph_number, none_found, last_glyph
// i_cfg_*   in   write enable   index 0 image_width, index 1 image_height
//
// One pixel per cycle while a frame streams in; the column flags rotate through a
// ring of cells, one cell per column. After the last pixel the ring shifts out one
// column per cycle, then a finish state issues the final item; pixels are not
// taken during that drain. A stalled output freezes the drain.
// Reset is synchronous; the flags need no clearing since row 0 rewrites them.
module glyph_column_segmenter
    import gcs_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gcs_pix_if.sink               i_pix,
    gcs_glyph_if.source           o_glyph,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned CB = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int unsigned RB = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    typedef enum logic [1:0] {
        ST_PIX,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    t_state          r_state;
    logic [CB-1:0]   r_wm1;
    logic [RB-1:0]   r_hm1;
    logic [CB-1:0]   r_col;
    logic [RB-1:0]   r_row;
    logic [RGB_W-1:0] r_empty;
    logic [CB-1:0]   r_x;
    logic [CB-1:0]   r_start;
    logic            r_prev_solid;
    logic            r_have;
    t_glyph          r_pend;
    logic [NUMBER_W:0] r_cnt;
    logic            r_ov;
    t_glyph          r_out;

    logic [MAX_WIDTH-1:0] flag;
    logic            accept;
    logic            first_px;
    logic [RGB_W-1:0] rgb;
    logic            match;
    logic            feed;
    logic            stall;
    logic            step;
    logic            at_end;
    logic            close;
    logic            load_out;
    logic [CB-1:0]   gstart;
    t_cell_ctl       ctl;
    t_glyph          n_glyph;

    assign accept   = i_pix.valid && i_pix.ready;
    assign rgb      = i_pix.pixel[RGB_W-1:0];
    assign first_px = (r_col == '0) && (r_row == '0);
    assign match    = first_px || (rgb == r_empty);
    assign feed     = (r_row == '0) ? match : (flag[0] && match);

    assign stall  = r_ov && !o_glyph.ready;
    assign step   = !stall;
    assign at_end = (r_x == r_wm1);
    assign close  = !flag[0] && (at_end || flag[1]);
    assign gstart = r_prev_solid ? r_x : r_start;

    assign load_out = step && (((r_state == ST_DRAIN) && close && r_have)
                               || (r_state == ST_FINISH));

    assign ctl.rotate = accept;
    assign ctl.shift  = (r_state == ST_DRAIN) && step;

    always_comb begin
        n_glyph.left   = COORD_W'(gstart);
        n_glyph.right  = COORD_W'(r_x);
        n_glyph.number = r_cnt[NUMBER_W-1:0];
        n_glyph.none   = 1'b0;
        n_glyph.last   = 1'b0;
    end

    for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
        logic nxt;
        if (i == MAX_WIDTH - 1) begin : g_top
            assign nxt = feed;
        end else begin : g_mid
            assign nxt = flag[i+1];
        end
        gcs_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (ctl),
            .i_is_tail (r_wm1 == CB'(i)),
            .i_next    (nxt),
            .i_feed    (feed),
            .o_flag    (flag[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_PIX;
            r_wm1        <= CB'(clamp_m1(RST_WIDTH, MAX_WIDTH));
            r_hm1        <= RB'(clamp_m1(RST_HEIGHT, MAX_HEIGHT));
            r_col        <= '0;
            r_row        <= '0;
            r_empty      <= '0;
            r_x          <= '0;
            r_prev_solid <= 1'b1;
            r_have       <= 1'b0;
            r_cnt        <= '0;
            r_ov         <= 1'b0;
        end else begin
            r_ov <= load_out || (r_ov && !o_glyph.ready);
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IMAGE_WIDTH) begin
                    r_wm1 <= CB'(clamp_m1(32'(i_cfg_data[WIDTH_REG_W-1:0]), MAX_WIDTH));
                end else begin
                    r_hm1 <= RB'(clamp_m1(32'(i_cfg_data[HEIGHT_REG_W-1:0]), MAX_HEIGHT));
                end
                r_col <= '0;
                r_row <= '0;
            end
            unique case (r_state)
                ST_PIX: begin
                    if (accept) begin
                        if (first_px) begin
                            r_empty <= rgb;
                        end
                        if (r_col == r_wm1) begin
                            r_col <= '0;
                            if (r_row == r_hm1) begin
                                r_row        <= '0;
                                r_state      <= ST_DRAIN;
                                r_x          <= '0;
                                r_prev_solid <= 1'b1;
                                r_have       <= 1'b0;
                                r_cnt        <= '0;
                            end else begin
                                r_row <= r_row + RB'(1);
                            end
                        end else begin
                            r_col <= r_col + CB'(1);
                        end
                    end
                end
                ST_DRAIN: begin
                    if (step) begin
                        r_x          <= r_x + CB'(1);
                        r_prev_solid <= flag[0];
                        if (!flag[0] && r_prev_solid) begin
                            r_start <= r_x;
                        end
                        if (close) begin
                            if (r_have) begin
                                r_out <= r_pend;
                            end
                            r_pend <= n_glyph;
                            r_have <= 1'b1;
                            r_cnt  <= r_cnt + (NUMBER_W+1)'(1);
                        end
                        if (at_end || (close && (r_cnt == (NUMBER_W+1)'(RESULT_LIMIT - 1)))) begin
                            r_state <= ST_FINISH;
                        end
                    end
                end
                ST_FINISH: begin
                    if (step) begin
                        if (r_have) begin
                            r_out <= '{left: r_pend.left, right: r_pend.right,
                                       number: r_pend.number, none: 1'b0, last: 1'b1};
                        end else begin
                            r_out <= '{left: '0, right: '0, number: '0, none: 1'b1, last: 1'b1};
                        end
                        r_have  <= 1'b0;
                        r_state <= ST_PIX;
                    end
                end
                default: begin
                    r_state <= ST_PIX;
                end
            endcase
        end
    end

    assign i_pix.ready          = (r_state == ST_PIX);
    assign o_glyph.valid        = r_ov;
    assign o_glyph.glyph_left   = r_out.left;
    assign o_glyph.glyph_right  = r_out.right;
    assign o_glyph.glyph_number = r_out.number;
    assign o_glyph.none_found   = r_out.none;
    assign o_glyph.last_glyph   = r_out.last;

endmodule

/* rtl/core/gcs_checker.sv */
module gcs_checker
    import gcs_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic [COORD_W-1:0]  i_left,
    input logic [COORD_W-1:0]  i_right,
    input logic [NUMBER_W-1:0] i_number,
    input logic                i_none,
    input logic                i_last
);

    a_none_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_none |-> i_last && i_left == '0 && i_right == '0 && i_number == '0)
        else $error("none item with nonzero fields");

    a_glyph_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_none |-> i_left <= i_right)
        else $error("glyph left beyond right");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_last |=> !i_out_valid)
        else $error("item after last of frame");

    a_drain_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("pixel input open during drain");

endmodule

bind glyph_column_segmenter gcs_checker u_gcs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_glyph.valid),
    .i_out_ready (o_glyph.ready),
    .i_left      (o_glyph.glyph_left),
    .i_right     (o_glyph.glyph_right),
    .i_number    (o_glyph.glyph_number),
    .i_none      (o_glyph.none_found),
    .i_last      (o_glyph.last_glyph)
);
